// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication; cons may be a sequence.
`define OLT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// File: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Beat types, table entry type and codes for the owned lock table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olt_pkg;

    localparam int KIND_W  = 2;
    localparam int LOCK_W  = 6;
    localparam int REQ_W   = 4;
    localparam int STAT_W  = 3;

    // request kinds
    localparam logic [KIND_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [KIND_W-1:0] REQ_ACQUIRE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_RELEASE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OWNED     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_OWNER = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [LOCK_W-1:0] lock_number;
        logic [REQ_W-1:0]  requester;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LOCK_W-1:0] granted_number;
    } t_result;

    typedef struct packed {
        logic             held;
        logic [REQ_W-1:0] owner;
    } t_entry;

endpackage

// File: rtl/olt_mem.sv
// ----------------------------------------------------------------------------
// olt_mem
// Lock entry RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olt_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            i_clk,
    input  logic [AW-1:0]   i_rd_addr,
    output olt_pkg::t_entry o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  olt_pkg::t_entry i_wr_data
);
    import olt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write on a collision; caller forwards
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/olt_exec.sv
// ----------------------------------------------------------------------------
// olt_exec
// Decision stage: checks the entry, builds the write-back, owns next_free
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module olt_exec #(
    parameter int NUM_LOCKS = 32,
    parameter int IW        = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  olt_pkg::t_req    i_req,
    input  olt_pkg::t_entry  i_entry,
    output logic             o_wr_en,
    output logic [IW-1:0]    o_wr_addr,
    output olt_pkg::t_entry  o_wr_data,
    output logic             o_done,
    output olt_pkg::t_result o_result
);
    import olt_pkg::*;

    localparam int FW = $clog2(NUM_LOCKS + 2);
    localparam int CW = (FW > LOCK_W) ? FW : LOCK_W;

    logic [FW-1:0] r_next_free;
    logic [FW-1:0] n_next_free;
    logic          r_done;
    t_result       r_result;
    t_result       n_result;

    logic [CW-1:0] num_w;
    logic [CW-1:0] nf_w;
    logic [CW-1:0] wr_idx;
    logic          exists;
    logic          own;

    assign num_w  = CW'(i_req.lock_number);
    assign nf_w   = CW'(r_next_free);
    assign exists = (num_w != '0) && (num_w < nf_w) && (num_w <= CW'(NUM_LOCKS));
    assign own    = i_entry.held && (i_entry.owner == i_req.requester);

    always_comb begin
        n_result.status         = ST_INVALID;
        n_result.granted_number = i_req.lock_number;
        n_next_free             = r_next_free;
        o_wr_en                 = 1'b0;
        o_wr_data               = '0;
        wr_idx                  = num_w - CW'(1);
        unique case (i_req.req_type)
            REQ_CREATE: begin
                if (nf_w > CW'(NUM_LOCKS)) begin
                    n_result.status         = ST_FULL;
                    n_result.granted_number = '0;
                end else begin
                    n_result.status         = ST_OK;
                    n_result.granted_number = LOCK_W'(r_next_free);
                    wr_idx                  = nf_w - CW'(1);
                    o_wr_en                 = i_vld;
                    n_next_free             = r_next_free + FW'(1);
                end
            end
            REQ_ACQUIRE: begin
                if (exists) begin
                    if (own) begin
                        n_result.status = ST_OWNED;
                    end else if (i_entry.held) begin
                        n_result.status = ST_BUSY;
                    end else begin
                        n_result.status = ST_OK;
                        o_wr_en         = i_vld;
                        o_wr_data.held  = 1'b1;
                        o_wr_data.owner = i_req.requester;
                    end
                end
            end
            REQ_RELEASE: begin
                if (exists) begin
                    if (own) begin
                        n_result.status = ST_OK;
                        o_wr_en         = i_vld;
                    end else begin
                        n_result.status = ST_NOT_OWNER;
                    end
                end
            end
            default: begin
                n_result.status = ST_INVALID;
            end
        endcase
    end

    assign o_wr_addr = wr_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= FW'(1);
            r_done      <= 1'b0;
        end else begin
            r_done <= i_vld;
            if (i_vld) begin
                r_next_free <= n_next_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `OLT_ASSERT_IMP(a_nf_range, 1'b1,
        (r_next_free != '0) && (CW'(r_next_free) <= CW'(NUM_LOCKS + 1)),
        "next_free out of range")
    `OLT_ASSERT_IMP(a_full_no_wr,
        i_vld && (i_req.req_type == REQ_CREATE) && (nf_w > CW'(NUM_LOCKS)),
        !o_wr_en, "create on a full table wrote an entry")

endmodule

// File: rtl/owned_lock_table.sv
// ----------------------------------------------------------------------------
// owned_lock_table
// Hardware lock table: create, acquire and release owned locks.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_req (kind, lock number, requester) and pulse start; a beat is
//   taken on every edge where start is high and busy is low. busy stays low:
//   the block takes one beat per cycle, back to back.
//   Each beat gives exactly one result beat on o_result, flagged by o_valid
//   for a single cycle, after passing the stage 0 -> stage 1 registers and
//   the result register in olt_exec. Throughput is one request per cycle;
//   in the read / decide / write-back loop on the entry RAM, a write that
//   collides with the following request's read is forwarded.
//   The receiver has no back-pressure: a result must be captured in the
//   cycle o_valid is high.
//   Reset (i_rst_n low, synchronous) drops the pipeline and sets next_free
//   to 1. The entry RAM is not cleared: create zeroes the entry it hands
//   out, and the entry of an uncreated lock is never used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module owned_lock_table #(
    parameter int NUM_LOCKS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  olt_pkg::t_req    i_req,
    output logic             o_valid,
    output olt_pkg::t_result o_result
);
    import olt_pkg::*;

    localparam int IW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int FW = $clog2(NUM_LOCKS + 2);
    localparam int CW = (FW > LOCK_W) ? FW : LOCK_W;

    // stage 0 -> stage 1 registers
    logic    r_vld;
    t_req    r_req;
    logic    r_byp;
    t_entry  r_byp_data;

    logic    accept;
    logic [IW-1:0] rd_addr;
    t_entry  rd_data;
    t_entry  entry;

    logic    wr_en;
    logic [IW-1:0] wr_addr;
    t_entry  wr_data;

    // never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // lock k lives at index k-1
    assign rd_addr = IW'(CW'(i_req.lock_number) - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
    end

    // payload and forwarding flag; write in flight hits this read
    always_ff @(posedge i_clk) begin
        r_req      <= i_req;
        r_byp      <= wr_en && (wr_addr == rd_addr);
        r_byp_data <= wr_data;
    end

    assign entry = r_byp ? r_byp_data : rd_data;

    olt_mem #(
        .DEPTH (NUM_LOCKS),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    olt_exec #(
        .NUM_LOCKS (NUM_LOCKS),
        .IW        (IW)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_vld),
        .i_req     (r_req),
        .i_entry   (entry),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_done    (o_valid),
        .o_result  (o_result)
    );

    `OLT_ASSERT_NXT(a_latency, accept, ##1 o_valid, "result beat missing two cycles after request")
    `OLT_ASSERT_NXT(a_no_spurious, !accept, ##1 !o_valid, "result beat without a request")
    `OLT_ASSERT_IMP(a_status_rng, o_valid, (o_result.status <= ST_FULL), "undefined status code")
    `OLT_ASSERT_IMP(a_wr_only_busy, wr_en, r_vld, "entry written with no request in flight")

endmodule
